// ===== hdl/pfe_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pfe_pkg
// Shared types and constants of the postfix expression evaluator: character
// codes, command format passed from front to back, error codes, FSM states.
// ----------------------------------------------------------------------------
package pfe_pkg;

  localparam int SYM_W       = 8;
  localparam int DATA_W      = 32;
  localparam int ERR_W       = 2;
  localparam int DIGIT_W     = 4;
  localparam int OUT_TDATA_W = 40;
  localparam int OUT_PAD_W   = OUT_TDATA_W - DATA_W - ERR_W;
  localparam int DIV_CNT_W   = $clog2(DATA_W);

  // command queue between front and back
  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);

  // ASCII codes recognised by the front end
  localparam logic [SYM_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [SYM_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [SYM_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [SYM_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [SYM_W-1:0] CH_CARET = 8'h5E;
  localparam logic [SYM_W-1:0] CH_ZERO  = 8'd48;
  localparam logic [SYM_W-1:0] CH_NINE  = 8'd57;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE      = 2'd0,
    ERR_OVERFLOW  = 2'd1,
    ERR_UNDERFLOW = 2'd2,
    ERR_DIVZERO   = 2'd3
  } err_code_t;

  typedef enum logic [1:0] {
    KIND_IGNORE,
    KIND_DIGIT,
    KIND_OP
  } kind_t;

  typedef enum logic [2:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_XOR
  } op_t;

  typedef struct packed {
    kind_t               kind;
    op_t                 op;
    logic [DIGIT_W-1:0]  digit;
    logic                last;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_FETCH,
    ST_POP_R,
    ST_POP_L,
    ST_EXEC,
    ST_DIV_WAIT,
    ST_PUSH,
    ST_FINAL,
    ST_EMIT
  } back_state_t;

  // keep only the first error of an expression
  function automatic err_code_t note_error(input err_code_t cur, input err_code_t code);
    return (cur == ERR_NONE) ? code : cur;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/pfe_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pfe_front
// Accepts characters, decodes them into digit / operator commands and drops
// ignorable characters unless they close the expression.
// ----------------------------------------------------------------------------
module pfe_front (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic [pfe_pkg::SYM_W-1:0] s_tdata,
  input  wire logic                      s_tvalid,
  output logic                           s_tready,
  input  wire logic                      s_tlast,
  output pfe_pkg::cmd_t                  cmd,
  output logic                           cmd_valid,
  input  wire logic                      cmd_ready
);
  import pfe_pkg::*;

  cmd_t cmd_dec;
  logic keep;

  // decode one character
  always_comb begin
    cmd_dec.kind  = KIND_IGNORE;
    cmd_dec.op    = OP_ADD;
    cmd_dec.digit = s_tdata[DIGIT_W-1:0];  // '0'..'9' carry the value in the low nibble
    cmd_dec.last  = s_tlast;
    priority if (s_tdata >= CH_ZERO && s_tdata <= CH_NINE) begin
      cmd_dec.kind = KIND_DIGIT;
    end else begin
      unique case (s_tdata)
        CH_PLUS: begin
          cmd_dec.kind = KIND_OP;
          cmd_dec.op   = OP_ADD;
        end
        CH_MINUS: begin
          cmd_dec.kind = KIND_OP;
          cmd_dec.op   = OP_SUB;
        end
        CH_STAR: begin
          cmd_dec.kind = KIND_OP;
          cmd_dec.op   = OP_MUL;
        end
        CH_SLASH: begin
          cmd_dec.kind = KIND_OP;
          cmd_dec.op   = OP_DIV;
        end
        CH_CARET: begin
          cmd_dec.kind = KIND_OP;
          cmd_dec.op   = OP_XOR;
        end
        default: cmd_dec.kind = KIND_IGNORE;
      endcase
    end
  end

  // an ignored character matters only when it ends the expression
  assign keep     = (cmd_dec.kind != KIND_IGNORE) || s_tlast;
  assign s_tready = !cmd_valid || cmd_ready;

  // output stage towards the command queue
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (s_tready) begin
      cmd_valid <= s_tvalid && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      cmd <= cmd_dec;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/pfe_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pfe_fifo
// Short command queue decoupling the decoder from the stack engine.
// ----------------------------------------------------------------------------
module pfe_fifo (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire pfe_pkg::cmd_t wr_data,
  input  wire logic          wr_valid,
  output logic               wr_ready,
  output pfe_pkg::cmd_t      rd_data,
  output logic               rd_valid,
  input  wire logic          rd_ready
);
  import pfe_pkg::*;

  localparam logic [CMDQ_AW:0] CNT_FULL = (CMDQ_AW+1)'(CMDQ_DEPTH);
  localparam logic [CMDQ_AW:0] CNT_ONE  = (CMDQ_AW+1)'(1);
  localparam logic [CMDQ_AW-1:0] PTR_ONE = CMDQ_AW'(1);

  cmd_t               slots [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wr_ptr;
  logic [CMDQ_AW-1:0] rd_ptr;
  logic [CMDQ_AW:0]   count;
  logic               wr_fire;
  logic               rd_fire;

  assign wr_ready = (count != CNT_FULL);
  assign rd_valid = (count != '0);
  assign rd_data  = slots[rd_ptr];
  assign wr_fire  = wr_valid && wr_ready;
  assign rd_fire  = rd_valid && rd_ready;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_fire) wr_ptr <= wr_ptr + PTR_ONE;
      if (rd_fire) rd_ptr <= rd_ptr + PTR_ONE;
      unique case ({wr_fire, rd_fire})
        2'b10:   count <= count + CNT_ONE;
        2'b01:   count <= count - CNT_ONE;
        default: count <= count;
      endcase
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (wr_fire) begin
      slots[wr_ptr] <= wr_data;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/pfe_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pfe_div
// Signed 32-bit divider, truncating toward zero. Restoring, one quotient bit
// per cycle on magnitudes, then a sign fix step. Divisor must be non-zero.
// ----------------------------------------------------------------------------
module pfe_div (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [pfe_pkg::DATA_W-1:0] dividend,
  input  wire logic [pfe_pkg::DATA_W-1:0] divisor,
  output logic                            done,
  output logic [pfe_pkg::DATA_W-1:0]      quotient
);
  import pfe_pkg::*;

  localparam logic [DIV_CNT_W-1:0] CNT_LAST = DIV_CNT_W'(DATA_W - 1);
  localparam logic [DIV_CNT_W-1:0] CNT_ONE  = DIV_CNT_W'(1);

  logic                 busy;
  logic                 fix;
  logic                 neg;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DATA_W-1:0]    mb;
  logic [DATA_W-1:0]    rem;
  logic [DATA_W-1:0]    quo;
  logic [DATA_W:0]      rem_sh;
  logic [DATA_W:0]      diff;
  logic                 ge;

  // one restoring step
  always_comb begin
    rem_sh = {rem, quo[DATA_W-1]};
    diff   = rem_sh - {1'b0, mb};
    ge     = !diff[DATA_W];
  end

  // sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fix  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CNT_LAST) begin
        busy <= 1'b0;
        fix  <= 1'b1;
      end else if (fix) begin
        fix  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
      mb  <= divisor[DATA_W-1] ? (DATA_W'(0) - divisor) : divisor;
      quo <= dividend[DATA_W-1] ? (DATA_W'(0) - dividend) : dividend;
      rem <= '0;
      cnt <= '0;
    end else if (busy) begin
      rem <= ge ? diff[DATA_W-1:0] : rem_sh[DATA_W-1:0];
      quo <= {quo[DATA_W-2:0], ge};
      cnt <= cnt + CNT_ONE;
    end
    if (fix) begin
      quotient <= neg ? (DATA_W'(0) - quo) : quo;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/pfe_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pfe_back
// Stack engine: operand stack memory, sequencer for push / pop / operate,
// ALU with multiplier, divider hand-off and result output register.
// ----------------------------------------------------------------------------
module pfe_back #(
  parameter int STACK_DEPTH = 32
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire pfe_pkg::cmd_t                   cmd,
  input  wire logic                            cmd_valid,
  output logic                                 cmd_ready,
  output logic                                 div_start,
  output logic [pfe_pkg::DATA_W-1:0]           div_dividend,
  output logic [pfe_pkg::DATA_W-1:0]           div_divisor,
  input  wire logic                            div_done,
  input  wire logic [pfe_pkg::DATA_W-1:0]      div_quotient,
  output logic [pfe_pkg::OUT_TDATA_W-1:0]      m_tdata,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready
);
  import pfe_pkg::*;

  localparam int ADDR_W = $clog2(STACK_DEPTH);
  localparam int TOP_W  = $clog2(STACK_DEPTH + 1);
  localparam logic [TOP_W-1:0] TOP_FULL = TOP_W'(STACK_DEPTH);
  localparam logic [TOP_W-1:0] TOP_ONE  = TOP_W'(1);

  back_state_t       state;
  back_state_t       state_next;
  logic [TOP_W-1:0]  top;
  logic [TOP_W-1:0]  top_dec;
  err_code_t         sticky;
  cmd_t              cur;
  logic [DATA_W-1:0] right;
  logic [DATA_W-1:0] res;
  logic [DATA_W-1:0] rd_data;
  logic [DATA_W-1:0] popped;
  logic [DATA_W-1:0] alu;
  logic              had;
  logic              out_free;
  logic              pop_req;
  logic              pop_ok;
  logic              push_req;
  logic              push_ok;
  logic              emit;
  logic              div_zero;

  logic [DATA_W-1:0] stack_mem [STACK_DEPTH];

  assign top_dec  = top - TOP_ONE;
  assign out_free = !m_tvalid || m_tready;
  // value of the last pop: -1 when the stack was empty
  assign popped   = had ? rd_data : '1;
  assign div_zero = (right == '0);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_FETCH: begin
        if (cmd_valid) begin
          unique case (cmd.kind)
            KIND_DIGIT: state_next = ST_PUSH;
            KIND_OP:    state_next = ST_POP_R;
            default:    state_next = cmd.last ? ST_FINAL : ST_FETCH;
          endcase
        end
      end
      ST_POP_R:    state_next = ST_POP_L;
      ST_POP_L:    state_next = ST_EXEC;
      ST_EXEC:     state_next = (cur.op == OP_DIV && !div_zero) ? ST_DIV_WAIT : ST_PUSH;
      ST_DIV_WAIT: state_next = div_done ? ST_PUSH : ST_DIV_WAIT;
      ST_PUSH:     state_next = cur.last ? ST_FINAL : ST_FETCH;
      ST_FINAL:    state_next = ST_EMIT;
      ST_EMIT:     state_next = out_free ? ST_FETCH : ST_EMIT;
      default:     state_next = ST_FETCH;
    endcase
  end

  // control outputs of the sequencer
  always_comb begin
    cmd_ready = (state == ST_FETCH);
    pop_req   = (state == ST_POP_R) || (state == ST_POP_L) || (state == ST_FINAL);
    pop_ok    = pop_req && (top != '0);
    push_req  = (state == ST_PUSH);
    push_ok   = push_req && (top != TOP_FULL);
    emit      = (state == ST_EMIT) && out_free;
    div_start = (state == ST_EXEC) && (cur.op == OP_DIV) && !div_zero;
  end

  assign div_dividend = popped;
  assign div_divisor  = right;

  // ALU: left operand comes straight from the stack read register
  always_comb begin
    unique case (cur.op)
      OP_ADD:  alu = popped + right;
      OP_SUB:  alu = popped - right;
      OP_MUL:  alu = popped * right;
      OP_XOR:  alu = popped ^ right;
      default: alu = '0;  // division result arrives from the divider
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_FETCH;
      top      <= '0;
      sticky   <= ERR_NONE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      priority if (emit)    top <= '0;
      else if (pop_ok)      top <= top_dec;
      else if (push_ok)     top <= top + TOP_ONE;
      else                  top <= top;

      priority if (emit)
        sticky <= ERR_NONE;
      else if (pop_req && !pop_ok)
        sticky <= note_error(sticky, ERR_UNDERFLOW);
      else if (state == ST_EXEC && cur.op == OP_DIV && div_zero)
        sticky <= note_error(sticky, ERR_DIVZERO);
      else if (push_req && !push_ok)
        sticky <= note_error(sticky, ERR_OVERFLOW);
      else
        sticky <= sticky;

      if (emit)          m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  // operand stack
  always_ff @(posedge clk) begin
    if (push_ok) begin
      stack_mem[top[ADDR_W-1:0]] <= res;
    end
    if (pop_ok) begin
      rd_data <= stack_mem[top_dec[ADDR_W-1:0]];
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (pop_req) had <= pop_ok;
    if (state == ST_FETCH && cmd_valid) begin
      cur <= cmd;
      res <= DATA_W'(cmd.digit);
    end
    if (state == ST_POP_L) right <= popped;
    if (state == ST_EXEC) res <= alu;
    if (state == ST_DIV_WAIT && div_done) res <= div_quotient;
    if (emit) m_tdata <= {{OUT_PAD_W{1'b0}}, sticky, popped};
  end

endmodule
`default_nettype wire

// ===== hdl/postfix_expression_evaluator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// postfix_expression_evaluator
// Evaluates postfix expressions arriving one character per request.
// ----------------------------------------------------------------------------
// Input channel s_*: one ASCII character per request in s_tdata; s_tlast
// closes the expression after that character. Digits push 0..9, + - * / ^
// operate on the two top operands (^ is exclusive or), other characters
// are dropped by the decoder unless they close the expression.
// Output channel m_*: one request per expression carrying the final value
// and the first error (none, overflow, underflow, divide by zero).
// The decoder and the stack engine are split by a four-entry command
// queue, so characters keep flowing while the engine works.
// Engine steps per character: a digit is fetched and pushed; + - * ^ are
// fetched, pop right and left operands, execute and push; / also waits on
// the 32-step divider (setup, steps, sign fix); the end marker adds the
// final pop and emit, which an ignored end character needs on its own.
// Once earlier work has drained, the end marker reaches m_tvalid through the
// decoder register, the queue, its engine steps and the output register.
// Reset empties the stack, the queue and the output register.
// When the receiver stalls, the result is held; the engine runs on to its
// next result, waits there, and the queue then fills before s_tready drops.
// ----------------------------------------------------------------------------
module postfix_expression_evaluator #(
  parameter int STACK_DEPTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [7:0]  s_tdata,   // [7:0] symbol
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic        s_tlast,   // end_of_expr
  output logic [39:0]      m_tdata,   // [31:0] value, [33:32] error_code, rest zero
  output logic             m_tvalid,
  input  wire logic        m_tready
);
  import pfe_pkg::*;

  cmd_t              f_cmd;
  logic              f_valid;
  logic              f_ready;
  cmd_t              q_cmd;
  logic              q_valid;
  logic              q_ready;
  logic              div_start;
  logic              div_done;
  logic [DATA_W-1:0] div_dividend;
  logic [DATA_W-1:0] div_divisor;
  logic [DATA_W-1:0] div_quotient;

  // character decoder
  pfe_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tlast   (s_tlast),
    .cmd       (f_cmd),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready)
  );

  // command queue
  pfe_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_data  (f_cmd),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .rd_data  (q_cmd),
    .rd_valid (q_valid),
    .rd_ready (q_ready)
  );

  // stack engine
  pfe_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd          (q_cmd),
    .cmd_valid    (q_valid),
    .cmd_ready    (q_ready),
    .div_start    (div_start),
    .div_dividend (div_dividend),
    .div_divisor  (div_divisor),
    .div_done     (div_done),
    .div_quotient (div_quotient),
    .m_tdata      (m_tdata),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready)
  );

  // iterative divider
  pfe_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // engine never restarts the divider while waiting on it
  a_div_no_restart: assert property (@(posedge clk) disable iff (rst)
    div_start |=> !div_start)
    else $error("divider restarted back to back");

  // a finishing division never overlaps a new one
  a_div_done_alone: assert property (@(posedge clk) disable iff (rst)
    div_done |-> !div_start)
    else $error("divider started while delivering a quotient");

  // no result survives reset
  a_out_clear: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid straight after reset");

endmodule
`default_nettype wire
